### sv/rgbcf_pkg.sv
package rgbcf_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int DEF_COEF_FRAC  = 12;

    localparam int PIX_W     = 8;
    localparam int RGB_W     = 3 * PIX_W;
    localparam int COEF_W    = 20;
    localparam int PROD_W    = COEF_W + PIX_W + 1;
    localparam int SUM_W     = PROD_W + 4;
    localparam int CFG_W     = 60;
    localparam int CFG_IDX_W = 3;
    localparam int FWIDTH_W  = 11;
    localparam int FHEIGHT_W = 13;
    localparam int FIFO_DEPTH = 8;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MID   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOT   = 3'd4;

    typedef logic signed [PROD_W-1:0] t_prod;

    typedef struct packed {
        logic               shift;
        logic signed [COEF_W-1:0] coef;
    } t_tap_ctl;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             done;
    } t_result;

endpackage

### sv/rgbcf_ram.sv
module rgbcf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

### sv/rgbcf_tap_cell.sv
module rgbcf_tap_cell (
    input  logic                        i_clk,
    input  rgbcf_pkg::t_tap_ctl         i_ctl,
    input  logic [rgbcf_pkg::RGB_W-1:0] i_pix,
    output logic [rgbcf_pkg::RGB_W-1:0] o_pix,
    output rgbcf_pkg::t_prod            o_prod [3]
);

    logic [rgbcf_pkg::RGB_W-1:0]         r_pix;
    logic signed [rgbcf_pkg::COEF_W-1:0] r_cf;
    rgbcf_pkg::t_prod                    r_prod [3];

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_pix <= i_pix;
            r_cf  <= i_ctl.coef;
        end
        for (int ch = 0; ch < 3; ch++) begin
            // drop a zero-weight tap outright, its pixel may be a stale store entry
            if (r_cf == '0) begin
                r_prod[ch] <= '0;
            end else begin
                r_prod[ch] <= r_cf *
                    $signed({1'b0, r_pix[ch*rgbcf_pkg::PIX_W +: rgbcf_pkg::PIX_W]});
            end
        end
    end

    assign o_pix  = r_pix;
    assign o_prod = r_prod;

endmodule

### sv/rgbcf_out_fifo.sv
module rgbcf_out_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  rgbcf_pkg::t_result   i_data,
    input  logic                 i_pop,
    output rgbcf_pkg::t_result   o_data,
    output logic [$clog2(rgbcf_pkg::FIFO_DEPTH+1)-1:0] o_count
);

    localparam int AW = $clog2(rgbcf_pkg::FIFO_DEPTH);
    localparam int CW = $clog2(rgbcf_pkg::FIFO_DEPTH+1);

    rgbcf_pkg::t_result r_mem [rgbcf_pkg::FIFO_DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + AW'(1);
            if (i_pop)  r_rd <= r_rd + AW'(1);
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_count = r_cnt;

endmodule

### sv/rgb_3x3_convolution_filter.sv
// Channel  | Direction | Handshake          | Payload
// request  | in        | i_valid / o_ready  | i_action, i_pixel_red/green/blue
// result   | out       | o_valid / i_ready  | o_filtered_red/green/blue, o_frame_done
// config   | in        | i_cfg_we           | i_cfg_index, i_cfg_data
// One request per clock while o_ready is high; each result passes the line-store
// read, the tap load and the product register before it enters the result queue.
// The line stores are one RAM holding both lines per column (read first, write next).
// Reset is synchronous; the line stores are not cleared.
// o_ready drops only when the 8-entry result queue plus in-flight results is full.
module rgb_3x3_convolution_filter #(
    parameter int MAX_WIDTH          = rgbcf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT         = rgbcf_pkg::DEF_MAX_HEIGHT,
    parameter int COEF_FRACTION_BITS = rgbcf_pkg::DEF_COEF_FRAC
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_action,
    input  logic [rgbcf_pkg::PIX_W-1:0]         i_pixel_red,
    input  logic [rgbcf_pkg::PIX_W-1:0]         i_pixel_green,
    input  logic [rgbcf_pkg::PIX_W-1:0]         i_pixel_blue,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [rgbcf_pkg::PIX_W-1:0]         o_filtered_red,
    output logic [rgbcf_pkg::PIX_W-1:0]         o_filtered_green,
    output logic [rgbcf_pkg::PIX_W-1:0]         o_filtered_blue,
    output logic                                o_frame_done,
    input  logic                                i_cfg_we,
    input  logic [rgbcf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rgbcf_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 2);
    localparam int YW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int HW  = $clog2(MAX_HEIGHT + 2);
    localparam int RGB = rgbcf_pkg::RGB_W;
    localparam int QW  = $clog2(rgbcf_pkg::FIFO_DEPTH + 1);

    // configuration
    logic [rgbcf_pkg::FWIDTH_W-1:0]  r_fwidth;
    logic [rgbcf_pkg::FHEIGHT_W-1:0] r_fheight;
    logic [rgbcf_pkg::CFG_W-1:0]     r_kern [3];
    logic size_wr;

    assign size_wr = i_cfg_we &&
        (i_cfg_index == rgbcf_pkg::REG_FRAME_WIDTH || i_cfg_index == rgbcf_pkg::REG_FRAME_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwidth  <= rgbcf_pkg::FWIDTH_W'(640);
            r_fheight <= rgbcf_pkg::FHEIGHT_W'(480);
            r_kern[0] <= '0;
            r_kern[1] <= rgbcf_pkg::CFG_W'(4096);
            r_kern[2] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rgbcf_pkg::REG_FRAME_WIDTH:  r_fwidth  <= i_cfg_data[rgbcf_pkg::FWIDTH_W-1:0];
                rgbcf_pkg::REG_FRAME_HEIGHT: r_fheight <= i_cfg_data[rgbcf_pkg::FHEIGHT_W-1:0];
                rgbcf_pkg::REG_KERNEL_TOP:   r_kern[0] <= i_cfg_data;
                rgbcf_pkg::REG_KERNEL_MID:   r_kern[1] <= i_cfg_data;
                rgbcf_pkg::REG_KERNEL_BOT:   r_kern[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective frame size, clamped
    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    always_comb begin
        if (r_fwidth == '0) begin
            eff_w = WW'(1);
        end else if (32'(r_fwidth) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_fwidth);
        end
        if (r_fheight == '0) begin
            eff_h = HW'(1);
        end else if (32'(r_fheight) > MAX_HEIGHT) begin
            eff_h = HW'(MAX_HEIGHT);
        end else begin
            eff_h = HW'(r_fheight);
        end
    end

    // position counters, advanced at request accept
    logic          accept;
    logic [CW-1:0] r_in_col;
    logic [WW-1:0] r_lag;
    logic [CW-1:0] r_x;
    logic [YW-1:0] r_y;
    logic          emit, x_end, y_end, last;
    logic [8:0]    mask;

    assign accept = i_valid && o_ready;
    assign emit   = (r_lag == eff_w + WW'(1));
    assign x_end  = (WW'(r_x) + WW'(1) >= eff_w);
    assign y_end  = (HW'(r_y) + HW'(1) >= eff_h);
    assign last   = emit && x_end && y_end;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int q = 0; q < 3; q++) begin
                mask[r*3+q] = !((r == 0 && r_y == '0) || (r == 2 && y_end) ||
                                (q == 0 && r_x == '0) || (q == 2 && x_end));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || size_wr) begin
            r_in_col <= '0;
            r_lag    <= '0;
            r_x      <= '0;
            r_y      <= '0;
        end else if (accept) begin
            if (last) begin
                r_in_col <= '0;
                r_lag    <= '0;
                r_x      <= '0;
                r_y      <= '0;
            end else begin
                if (WW'(r_in_col) + WW'(1) >= eff_w) r_in_col <= '0;
                else                                 r_in_col <= r_in_col + CW'(1);
                if (!emit) begin
                    r_lag <= r_lag + WW'(1);
                end else if (x_end) begin
                    r_x <= '0;
                    r_y <= r_y + YW'(1);
                end else begin
                    r_x <= r_x + CW'(1);
                end
            end
        end
    end

    // stage A: line store read in flight
    logic          r_a_v, r_a_emit, r_a_last, r_a_hit;
    logic [CW-1:0] r_a_col;
    logic [RGB-1:0] r_a_pix;
    logic [8:0]    r_a_mask;
    logic [2*RGB-1:0] r_fwd, ram_q, lines;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= accept;
        end
        if (accept) begin
            r_a_emit <= emit;
            r_a_last <= last;
            r_a_col  <= r_in_col;
            r_a_mask <= mask;
            // hold the column being written this edge for the read bypass
            r_a_hit  <= r_a_v && (r_a_col == r_in_col);
            r_a_pix  <= i_action ? '0 : {i_pixel_blue, i_pixel_green, i_pixel_red};
        end
        if (r_a_v) begin
            r_fwd <= {lines[RGB-1:0], r_a_pix};
        end
    end

    rgbcf_ram #(.WIDTH(2*RGB), .DEPTH(MAX_WIDTH)) u_lines (
        .i_clk   (i_clk),
        .i_we    (r_a_v),
        .i_waddr (r_a_col),
        .i_wdata ({lines[RGB-1:0], r_a_pix}),
        .i_re    (accept),
        .i_raddr (r_in_col),
        .o_rdata (ram_q)
    );

    assign lines = r_a_hit ? r_fwd : ram_q;

    // window: three rows of three cells; column 2 takes the new taps
    logic [RGB-1:0]        row_in [3];
    logic [RGB-1:0]        tap_pix [9];
    rgbcf_pkg::t_prod      tap_prod [9][3];
    rgbcf_pkg::t_tap_ctl   tap_ctl [9];

    assign row_in[0] = lines[2*RGB-1:RGB];
    assign row_in[1] = lines[RGB-1:0];
    assign row_in[2] = r_a_pix;

    for (genvar r = 0; r < 3; r++) begin : g_row
        for (genvar q = 0; q < 3; q++) begin : g_col
            logic [RGB-1:0] cell_in;
            if (q == 2) begin : g_edge
                assign cell_in = row_in[r];
            end else begin : g_inner
                assign cell_in = tap_pix[r*3+q+1];
            end
            assign tap_ctl[r*3+q].shift = r_a_v;
            assign tap_ctl[r*3+q].coef  = r_a_mask[r*3+q] ?
                $signed(r_kern[r][q*rgbcf_pkg::COEF_W +: rgbcf_pkg::COEF_W]) : '0;
            rgbcf_tap_cell u_cell (
                .i_clk  (i_clk),
                .i_ctl  (tap_ctl[r*3+q]),
                .i_pix  (cell_in),
                .o_pix  (tap_pix[r*3+q]),
                .o_prod (tap_prod[r*3+q])
            );
        end
    end

    // stages B (products forming) and C (products ready)
    logic r_b_v, r_b_last, r_c_v, r_c_last;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            r_b_v <= r_a_v && r_a_emit;
            r_c_v <= r_b_v;
        end
        r_b_last <= r_a_last;
        r_c_last <= r_b_last;
    end

    logic signed [rgbcf_pkg::SUM_W-1:0] sum [3];
    logic signed [rgbcf_pkg::SUM_W-1:0] shifted [3];
    logic [rgbcf_pkg::PIX_W-1:0]        pix_out [3];
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sum[ch] = '0;
            for (int t = 0; t < 9; t++) begin
                sum[ch] = sum[ch] + rgbcf_pkg::SUM_W'(tap_prod[t][ch]);
            end
            shifted[ch] = sum[ch] >>> COEF_FRACTION_BITS;
            if (sum[ch] < 0)          pix_out[ch] = '0;
            else if (shifted[ch] > 255) pix_out[ch] = 8'hFF;
            else                       pix_out[ch] = shifted[ch][rgbcf_pkg::PIX_W-1:0];
        end
    end

    rgbcf_pkg::t_result res_in, res_out;
    logic [QW-1:0] q_cnt;
    assign res_in = '{red: pix_out[0], green: pix_out[1], blue: pix_out[2], done: r_c_last};

    rgbcf_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_c_v),
        .i_data  (res_in),
        .i_pop   (o_valid && i_ready),
        .o_data  (res_out),
        .o_count (q_cnt)
    );

    // reserve queue room for every request still in the pipe
    assign o_ready = (32'(q_cnt) + 32'(r_a_v) + 32'(r_b_v) + 32'(r_c_v))
                     < rgbcf_pkg::FIFO_DEPTH;
    assign o_valid          = (q_cnt != '0);
    assign o_filtered_red   = res_out.red;
    assign o_filtered_green = res_out.green;
    assign o_filtered_blue  = res_out.blue;
    assign o_frame_done     = res_out.done;

endmodule

### tb/rgb_3x3_convolution_filter_tb.sv
`timescale 1ns / 100ps

module rgb_3x3_convolution_filter_tb;

    localparam int LINE_DEPTH = rgbcf_pkg::DEF_MAX_WIDTH;
    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_REQUESTS = 100;

    // Running convolution of the request stream plus the queue of pixels it predicts.
    class conv3x3_model;
        bit [rgbcf_pkg::FWIDTH_W-1:0]  width_reg;
        bit [rgbcf_pkg::FHEIGHT_W-1:0] height_reg;
        bit [rgbcf_pkg::CFG_W-1:0]     kernel_row[3];
        bit [rgbcf_pkg::RGB_W-1:0]     upper_line[LINE_DEPTH];
        bit [rgbcf_pkg::RGB_W-1:0]     lower_line[LINE_DEPTH];
        bit [rgbcf_pkg::RGB_W-1:0]     window[3][3];
        int unsigned                   in_col, in_row, out_col, out_row, seen;
        rgbcf_pkg::t_result            expected_pixels[$];
        int                            errors;

        function new();
            width_reg = 640;
            height_reg = 480;
            kernel_row[0] = '0;
            kernel_row[1] = 60'd4096;
            kernel_row[2] = '0;
            foreach (upper_line[i]) begin
                upper_line[i] = '0;
                lower_line[i] = '0;
            end
            foreach (window[r, q]) window[r][q] = '0;
            errors = 0;
            clear_position();
        endfunction

        function void clear_position();
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
            seen = 0;
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0) return 1;
            if (width_reg > rgbcf_pkg::DEF_MAX_WIDTH) return rgbcf_pkg::DEF_MAX_WIDTH;
            return width_reg;
        endfunction

        function int unsigned eff_height();
            if (height_reg == 0) return 1;
            if (height_reg > rgbcf_pkg::DEF_MAX_HEIGHT) return rgbcf_pkg::DEF_MAX_HEIGHT;
            return height_reg;
        endfunction

        function void write_reg(bit [rgbcf_pkg::CFG_IDX_W-1:0] idx,
                                bit [rgbcf_pkg::CFG_W-1:0] data);
            case (idx)
                rgbcf_pkg::REG_FRAME_WIDTH: begin
                    width_reg = data[rgbcf_pkg::FWIDTH_W-1:0];
                    clear_position();
                end
                rgbcf_pkg::REG_FRAME_HEIGHT: begin
                    height_reg = data[rgbcf_pkg::FHEIGHT_W-1:0];
                    clear_position();
                end
                rgbcf_pkg::REG_KERNEL_TOP: kernel_row[0] = data;
                rgbcf_pkg::REG_KERNEL_MID: kernel_row[1] = data;
                rgbcf_pkg::REG_KERNEL_BOT: kernel_row[2] = data;
                default: ;
            endcase
        endfunction

        function bit [rgbcf_pkg::PIX_W-1:0] clamp_pixel(longint s);
            if (s < 0) return '0;
            s = s >>> rgbcf_pkg::DEF_COEF_FRAC;
            if (s > 255) return 8'd255;
            return s[rgbcf_pkg::PIX_W-1:0];
        endfunction

        function void note_request(bit drain, bit [rgbcf_pkg::PIX_W-1:0] red,
                                   bit [rgbcf_pkg::PIX_W-1:0] green,
                                   bit [rgbcf_pkg::PIX_W-1:0] blue);
            bit [rgbcf_pkg::RGB_W-1:0] pix;
            int unsigned c, w, h, x, y;
            longint acc[3];
            logic signed [rgbcf_pkg::COEF_W-1:0] cf;
            rgbcf_pkg::t_result res;
            w = eff_width();
            h = eff_height();
            pix = drain ? '0 : {blue, green, red};
            c = (in_col >= LINE_DEPTH) ? 0 : in_col;
            for (int r = 0; r < 3; r++) begin
                window[r][0] = window[r][1];
                window[r][1] = window[r][2];
            end
            window[0][2] = upper_line[c];
            window[1][2] = lower_line[c];
            window[2][2] = pix;
            upper_line[c] = lower_line[c];
            lower_line[c] = pix;
            if (in_col + 1 >= w) begin
                in_col = 0;
                in_row++;
            end else begin
                in_col++;
            end
            seen++;
            if (seen <= w + 1) return;

            x = out_col;
            y = out_row;
            acc = '{0, 0, 0};
            for (int r = 0; r < 3; r++) begin
                // taps outside the frame weigh nothing
                if ((r == 0 && y == 0) || (r == 2 && y + 1 >= h)) continue;
                for (int q = 0; q < 3; q++) begin
                    if ((q == 0 && x == 0) || (q == 2 && x + 1 >= w)) continue;
                    cf = kernel_row[r][rgbcf_pkg::COEF_W*q +: rgbcf_pkg::COEF_W];
                    for (int ch = 0; ch < 3; ch++)
                        acc[ch] += longint'(cf) *
                            longint'(window[r][q][rgbcf_pkg::PIX_W*ch +: rgbcf_pkg::PIX_W]);
                end
            end
            res.red = clamp_pixel(acc[0]);
            res.green = clamp_pixel(acc[1]);
            res.blue = clamp_pixel(acc[2]);
            res.done = (x + 1 >= w) && (y + 1 >= h);
            expected_pixels.push_back(res);
            if (res.done) begin
                clear_position();
            end else if (x + 1 >= w) begin
                out_col = 0;
                out_row++;
            end else begin
                out_col++;
            end
        endfunction

        function void check_result(rgbcf_pkg::t_result got);
            rgbcf_pkg::t_result want;
            if (expected_pixels.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", got);
                return;
            end
            want = expected_pixels.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10) $display("pixel mismatch: expected %p, got %p", want, got);
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            o_ready;
    logic                            i_action = 1'b0;
    logic [rgbcf_pkg::PIX_W-1:0]     i_pixel_red = '0;
    logic [rgbcf_pkg::PIX_W-1:0]     i_pixel_green = '0;
    logic [rgbcf_pkg::PIX_W-1:0]     i_pixel_blue = '0;
    logic                            o_valid;
    logic                            i_ready = 1'b0;
    logic [rgbcf_pkg::PIX_W-1:0]     o_filtered_red;
    logic [rgbcf_pkg::PIX_W-1:0]     o_filtered_green;
    logic [rgbcf_pkg::PIX_W-1:0]     o_filtered_blue;
    logic                            o_frame_done;
    logic                            i_cfg_we = 1'b0;
    logic [rgbcf_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [rgbcf_pkg::CFG_W-1:0]     i_cfg_data = '0;

    conv3x3_model model = new();
    int  requests_sent = 0;
    bit  no_idle = 1'b0;
    int  stall_left = 0;
    int  idle_cycles = 0;
    int  cur_w = 640;
    int  cur_h = 480;

    rgb_3x3_convolution_filter u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_action        (i_action),
        .i_pixel_red     (i_pixel_red),
        .i_pixel_green   (i_pixel_green),
        .i_pixel_blue    (i_pixel_blue),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_filtered_red  (o_filtered_red),
        .o_filtered_green(o_filtered_green),
        .o_filtered_blue (o_filtered_blue),
        .o_frame_done    (o_frame_done),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: check, then decide whether to stall next cycle
    always @(posedge i_clk) begin
        rgbcf_pkg::t_result got;
        if (i_rst_n && o_valid && i_ready) begin
            got.red = o_filtered_red;
            got.green = o_filtered_green;
            got.blue = o_filtered_blue;
            got.done = o_frame_done;
            model.check_result(got);
        end
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 5) == 0) stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= STALL_LIMIT) begin
                    $display("rgb_3x3_convolution_filter_tb: done, errors");
                    $finish;
                end
            end
        end
    end

    task automatic send_request(bit drain, bit [rgbcf_pkg::PIX_W-1:0] red,
                                bit [rgbcf_pkg::PIX_W-1:0] green,
                                bit [rgbcf_pkg::PIX_W-1:0] blue);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= drain;
        i_pixel_red <= red;
        i_pixel_green <= green;
        i_pixel_blue <= blue;
        do @(posedge i_clk); while (!o_ready);
        model.note_request(drain, red, green, blue);
        requests_sent++;
    endtask

    task automatic send_pixel(bit drain);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) send_request(drain, 8'd0, 8'd0, 8'd0);
        else if (roll == 1) send_request(drain, 8'd255, 8'd255, 8'd255);
        else send_request(drain, $urandom, $urandom, $urandom);
    endtask

    // hold requests until every predicted pixel is out, plus pipeline slack
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (model.pending() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic configure(int w, int h, bit [rgbcf_pkg::CFG_W-1:0] k_top,
                             bit [rgbcf_pkg::CFG_W-1:0] k_mid,
                             bit [rgbcf_pkg::CFG_W-1:0] k_bot);
        bit [rgbcf_pkg::CFG_W-1:0] vals[5];
        bit [rgbcf_pkg::CFG_IDX_W-1:0] idx[5];
        wait_idle();
        vals = '{w, h, k_top, k_mid, k_bot};
        idx = '{rgbcf_pkg::REG_FRAME_WIDTH, rgbcf_pkg::REG_FRAME_HEIGHT,
                rgbcf_pkg::REG_KERNEL_TOP, rgbcf_pkg::REG_KERNEL_MID,
                rgbcf_pkg::REG_KERNEL_BOT};
        for (int i = 0; i < 5; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            model.write_reg(idx[i], vals[i]);
        end
        // unmapped index: must leave everything alone
        if ($urandom_range(0, 3) == 0) begin
            i_cfg_index <= rgbcf_pkg::CFG_IDX_W'(rgbcf_pkg::REG_KERNEL_BOT +
                                                 $urandom_range(1, 3));
            i_cfg_data <= rgbcf_pkg::CFG_W'({$urandom, $urandom});
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cur_w = model.eff_width();
        cur_h = model.eff_height();
    endtask

    function automatic bit [rgbcf_pkg::CFG_W-1:0] coef_row(int left, int mid, int right);
        bit [rgbcf_pkg::COEF_W-1:0] a, b, c;
        a = left;
        b = mid;
        c = right;
        return {c, b, a};
    endfunction

    function automatic bit [rgbcf_pkg::CFG_W-1:0] random_row();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 2) return rgbcf_pkg::CFG_W'({$urandom, $urandom});
        if (roll < 4) return coef_row(-$urandom_range(0, 5000), $urandom_range(0, 5000),
                                      $urandom_range(0, 1) ? 20'h80000 : 20'h7FFFF);
        return coef_row(int'($urandom_range(0, 1400)) - 400, int'($urandom_range(0, 1400)) - 400,
                        int'($urandom_range(0, 1400)) - 400);
    endfunction

    task automatic run_frame(int kind);
        int n;
        case (kind)
            0: begin
                repeat (cur_w * cur_h) send_pixel(1'b0);
                repeat (cur_w + 1) send_pixel(1'b1);
            end
            1: begin
                // early drain and stray pixels mixed in
                n = $urandom_range(1, cur_w * cur_h + cur_w + 1);
                repeat (n) send_pixel($urandom_range(0, 3) == 0);
            end
            default: begin
                n = $urandom_range(0, cur_w * cur_h - 1);
                repeat (n) send_pixel(1'b0);
                repeat (cur_w + 1) send_pixel(1'b1);
            end
        endcase
    endtask

    initial begin
        int start_count;
        int w, h, roll;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // box blur on a small frame with extreme pixel values
        configure(3, 3, coef_row(455, 455, 455), coef_row(455, 455, 455),
                  coef_row(455, 455, 455));
        for (int i = 0; i < 9; i++)
            if (i % 2 == 0) send_request(1'b0, 8'd255, 8'd0, 8'd255);
            else send_request(1'b0, 8'd0, 8'd255, 8'd0);
        repeat (4) send_request(1'b1, 8'd0, 8'd0, 8'd0);
        // extreme coefficients
        configure(2, 2, coef_row(20'h7FFFF, 20'h80000, 20'h7FFFF),
                  coef_row(20'h80000, 20'h7FFFF, 20'h80000), coef_row(0, 20'h7FFFF, 0));
        run_frame(0);
        // zero sizes act as one
        configure(0, 0, random_row(), coef_row(0, 4096, 0), random_row());
        run_frame(0);
        // widest line, a few results past the lag, then cut short by a size write
        configure(2047, 1, random_row(), random_row(), random_row());
        no_idle = 1'b1;
        repeat (cur_w + 6) send_pixel(1'b0);
        no_idle = 1'b0;
        // tallest frame cut short by a size write
        configure(2, 8191, random_row(), random_row(), random_row());
        repeat (30) send_pixel($urandom_range(0, 7) == 0);

        start_count = requests_sent;
        while (requests_sent - start_count < RANDOM_REQUESTS) begin
            roll = $urandom_range(0, 19);
            w = (roll == 0) ? 0 : (roll == 1) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            h = (roll == 2) ? 0 : $urandom_range(1, 6);
            configure(w, h, random_row(), random_row(), random_row());
            no_idle = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(1, 3)) begin
                roll = $urandom_range(0, 9);
                run_frame(roll < 7 ? 0 : roll < 9 ? 1 : 2);
            end
        end
        no_idle = 1'b0;
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (model.errors == 0 && model.pending() == 0) begin
            $display("rgb_3x3_convolution_filter_tb: done, clean");
        end else begin
            $display("rgb_3x3_convolution_filter_tb: done, errors");
        end
        $finish;
    end

endmodule
